>>> design/jsonc_comment_whitespace_stripper_macros.svh
// ----------------------------------------------------------------------------
// JSONC stripper assertion macros
// Concurrent assertion wrappers shared by the stripper RTL files.
// ----------------------------------------------------------------------------
`ifndef JSONC_COMMENT_WHITESPACE_STRIPPER_MACROS_SVH
`define JSONC_COMMENT_WHITESPACE_STRIPPER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge outside reset.
`define JCWS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("jcws assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define JCWS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("jcws assertion failed");

`else

`define JCWS_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define JCWS_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

>>> design/jcws_pkg.sv
// ----------------------------------------------------------------------------
// JSONC stripper package
// Character codes, scan modes, result kinds and shared result types.
// ----------------------------------------------------------------------------
package jcws_pkg;

   localparam int unsigned MODE_W = 3;

   // Scan modes.
   localparam logic [MODE_W-1:0] MODE_NORMAL     = 3'd0;
   localparam logic [MODE_W-1:0] MODE_STR        = 3'd1;
   localparam logic [MODE_W-1:0] MODE_STR_ESC    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_BLOCK      = 3'd3;
   localparam logic [MODE_W-1:0] MODE_BLOCK_STAR = 3'd4;
   localparam logic [MODE_W-1:0] MODE_LINE       = 3'd5;

   // Result kinds.
   localparam logic [1:0] KIND_DATA      = 2'd0;
   localparam logic [1:0] KIND_END_OK    = 2'd1;
   localparam logic [1:0] KIND_END_STR   = 2'd2;
   localparam logic [1:0] KIND_END_BLOCK = 2'd3;

   // Characters of interest.
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
   } res_item_type;

   // Up to three results from one input byte, item[0] first.
   typedef struct packed {
      logic [1:0]         count;
      res_item_type [2:0] item;
   } res_set_type;

endpackage

>>> design/jsonc_comment_whitespace_stripper.sv
// ----------------------------------------------------------------------------
// JSONC comment and whitespace stripper
// Removes whitespace and comments from JSON-with-comments text, copying
// quoted strings untouched, and reports how each text ended.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Content                                   Handshake
//  req_     in   text byte, tlast marks the final byte     tvalid/tready
//  rsp_     out  cleaned byte or end code (tuser kind),    tvalid/tready
//                tlast on the last result of each request
//
// A request is registered on acceptance and decoded once the result buffer is free,
// when its results (none to three) load that buffer, which then presents them.
// One request per cycle while each causes at most one result and rsp_ is ready; two
// or three results leave the single result port in turn and stall intake meanwhile.
// Back-pressure on rsp_ holds the buffer, then the request register, then req_tready.
// Reset (synchronous, active high) empties both and returns the scanner to normal text.
// ----------------------------------------------------------------------------
`include "jsonc_comment_whitespace_stripper_macros.svh"

module jsonc_comment_whitespace_stripper (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,   // in_last
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [1:0] rsp_tuser,   // [1:0] out_kind
   output logic       rsp_tlast    // run_last
);
   import jcws_pkg::*;

   // Request register: one raw byte waiting to be decoded.
   logic              in_valid_ff;
   logic              in_valid_in;
   logic [7:0]        in_byte_ff;
   logic              in_last_ff;

   // Scanner state: current mode and whether a slash is pending.
   logic [MODE_W-1:0] mode_ff;
   logic [MODE_W-1:0] mode_in;
   logic              slash_ff;
   logic              slash_in;

   logic              req_take;
   logic              load;
   logic              buf_free;
   res_set_type       res_set;

   // A registered request is decoded in the cycle the result buffer can take
   // its results; the request register then frees up in the same cycle.
   assign load       = in_valid_ff && buf_free;
   assign req_tready = !in_valid_ff || load;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (load) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   jcws_decode u_decode (
      .mode       (mode_ff),
      .slash_held (slash_ff),
      .in_byte    (in_byte_ff),
      .in_last    (in_last_ff),
      .next_mode  (mode_in),
      .next_slash (slash_in),
      .res_set    (res_set)
   );

   // The scanner advances only when a request is actually decoded.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_NORMAL;
         slash_ff <= 1'b0;
      end else if (load) begin
         mode_ff  <= mode_in;
         slash_ff <= slash_in;
      end
   end

   jcws_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .load_set   (res_set),
      .free       (buf_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // A pending slash only ever exists in normal text.
   `JCWS_ASSERT_IMP(a_slash_in_normal, clock, reset, slash_ff, mode_ff == MODE_NORMAL)
   // The scanner only ever holds one of the six defined modes.
   `JCWS_ASSERT_IMP(a_mode_legal, clock, reset, 1'b1, mode_ff <= MODE_LINE)
   // The final byte of a text always leaves the scanner fresh for the next.
   `JCWS_ASSERT_NXT(a_end_clears, clock, reset, load && in_last_ff,
                    (mode_ff == MODE_NORMAL) && !slash_ff)

endmodule

>>> design/jcws_decode.sv
// ----------------------------------------------------------------------------
// JSONC stripper decode
// Next scan state and the ordered result set for one registered byte.
// ----------------------------------------------------------------------------
module jcws_decode (
   input  logic [jcws_pkg::MODE_W-1:0] mode,
   input  logic                        slash_held,
   input  logic [7:0]                  in_byte,
   input  logic                        in_last,
   output logic [jcws_pkg::MODE_W-1:0] next_mode,
   output logic                        next_slash,
   output jcws_pkg::res_set_type       res_set
);
   import jcws_pkg::*;

   logic       blank;
   logic       emit_slash;
   logic       emit_mid;
   logic       emit_end;
   logic       normal_go;
   logic [7:0] mid_byte;
   logic [1:0] end_kind;
   logic [1:0] idx_mid;
   logic [1:0] idx_end;

   assign blank = (in_byte == CH_SPACE) || ((in_byte >= CH_TAB) && (in_byte <= CH_CR));

   always_comb begin
      next_mode  = mode;
      next_slash = slash_held;
      emit_slash = 1'b0;
      emit_mid   = 1'b0;
      emit_end   = 1'b0;
      normal_go  = 1'b0;
      mid_byte   = in_byte;
      end_kind   = KIND_END_OK;

      unique case (mode)
         MODE_STR: begin
            emit_mid = 1'b1;
            if (in_byte == CH_BSLASH) begin
               next_mode = MODE_STR_ESC;
            end else if (in_byte == CH_QUOTE) begin
               next_mode = MODE_NORMAL;
            end
         end
         MODE_STR_ESC: begin
            emit_mid  = 1'b1;
            next_mode = MODE_STR;
         end
         MODE_BLOCK: begin
            if (in_byte == CH_STAR) begin
               next_mode = MODE_BLOCK_STAR;
            end
         end
         MODE_BLOCK_STAR: begin
            if (in_byte == CH_SLASH) begin
               next_mode = MODE_NORMAL;
            end else if (in_byte != CH_STAR) begin
               next_mode = MODE_BLOCK;
            end
         end
         MODE_LINE: begin
            if (in_byte == CH_NL) begin
               next_mode = MODE_NORMAL;
            end
         end
         default: begin
            next_mode = MODE_NORMAL;
            if (slash_held) begin
               next_slash = 1'b0;
               if (in_byte == CH_STAR) begin
                  next_mode = MODE_BLOCK;
               end else if (in_byte == CH_SLASH) begin
                  next_mode = MODE_LINE;
               end else begin
                  emit_slash = 1'b1;
                  normal_go  = 1'b1;
               end
            end else begin
               normal_go = 1'b1;
            end
         end
      endcase

      // Ordinary byte in normal text, after any released slash.
      if (normal_go && !blank) begin
         if (in_byte == CH_SLASH) begin
            next_slash = 1'b1;
         end else begin
            emit_mid = 1'b1;
            if (in_byte == CH_QUOTE) begin
               next_mode = MODE_STR;
            end
         end
      end

      // End of text: a slash still waiting goes out as data (it never shares
      // a step with an emitted byte), then the end result.
      if (in_last) begin
         if (next_slash) begin
            emit_mid = 1'b1;
            mid_byte = CH_SLASH;
         end
         if (next_mode inside {MODE_STR, MODE_STR_ESC}) begin
            end_kind = KIND_END_STR;
         end else if (next_mode inside {MODE_BLOCK, MODE_BLOCK_STAR}) begin
            end_kind = KIND_END_BLOCK;
         end
         emit_end   = 1'b1;
         next_mode  = MODE_NORMAL;
         next_slash = 1'b0;
      end
   end

   assign idx_mid = {1'b0, emit_slash};
   assign idx_end = {1'b0, emit_slash} + {1'b0, emit_mid};

   always_comb begin
      res_set       = '0;
      res_set.count = idx_end + {1'b0, emit_end};
      if (emit_slash) begin
         res_set.item[0].kind = KIND_DATA;
         res_set.item[0].data = CH_SLASH;
      end
      if (emit_mid) begin
         res_set.item[idx_mid].kind = KIND_DATA;
         res_set.item[idx_mid].data = mid_byte;
      end
      if (emit_end) begin
         res_set.item[idx_end].kind = end_kind;
         res_set.item[idx_end].data = 8'd0;
      end
   end

endmodule

>>> design/jcws_out_buf.sv
// ----------------------------------------------------------------------------
// JSONC stripper result buffer
// Holds the results of one byte and presents them one per cycle while rsp_tready is high.
// ----------------------------------------------------------------------------
`include "jsonc_comment_whitespace_stripper_macros.svh"

module jcws_out_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  jcws_pkg::res_set_type load_set,
   output logic                  free,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,   // [7:0] out_byte
   output logic [1:0]            rsp_tuser,   // [1:0] out_kind
   output logic                  rsp_tlast    // run_last
);
   import jcws_pkg::*;

   logic [1:0]         cnt_ff;
   logic [1:0]         cnt_in;
   res_item_type [2:0] slot_ff;
   res_item_type [2:0] slot_in;
   logic               take;

   assign take       = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = slot_ff[0].data;
   assign rsp_tuser  = slot_ff[0].kind;
   assign rsp_tlast  = (cnt_ff == 2'd1);

   // The buffer can take a new set when empty or when its final result leaves now.
   assign free = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_tready);

   always_comb begin
      cnt_in  = cnt_ff;
      slot_in = slot_ff;
      if (load) begin
         cnt_in  = load_set.count;
         slot_in = load_set.item;
      end else if (take) begin
         cnt_in     = cnt_ff - 2'd1;
         slot_in[0] = slot_ff[1];
         slot_in[1] = slot_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   `JCWS_ASSERT_IMP(a_load_when_free, clock, reset, load, free)
   `JCWS_ASSERT_NXT(a_load_shows, clock, reset, load && (load_set.count != 2'd0), rsp_tvalid)
   `JCWS_ASSERT_IMP(a_end_is_last, clock, reset, rsp_tvalid && (rsp_tuser != KIND_DATA),
                    rsp_tlast && (rsp_tdata == 8'd0))

endmodule
